// ===== hdl/bfau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfau_pkg - shared types and constants of the GF(2^m) arithmetic unit
// Action codes, register indexes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package bfau_pkg;

  // Port field widths
  localparam int FIELD_W    = 16;
  localparam int DEGREE_W   = 5;
  localparam int POLY_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  // Default of the largest supported degree
  localparam int DEFAULT_MAX_DEGREE = 16;

  // Multiplier bits consumed per cycle
  localparam int DIGIT_BITS = 4;

  // Register reset values
  localparam logic [DEGREE_W-1:0] DEGREE_RESET = 5'd8;
  localparam logic [POLY_W-1:0]   POLY_RESET   = 17'd283;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_MUL = 2'd1,
    ACT_DIV = 2'd2,
    ACT_POW = 2'd3
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE = 1'b0,
    CFG_POLY   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL
  } state_t;

  // Destination of the multiplication in flight
  typedef enum logic [1:0] {
    PH_ACC,
    PH_SQR,
    PH_FIN
  } phase_t;

endpackage : bfau_pkg
`default_nettype wire

// ===== hdl/binary_field_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit - GF(2^m) polynomial basis arithmetic
// Add, multiply, divide and power over a configurable binary field, all
// products computed on one shared digit-serial multiplier.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                      | Handshake
//  ---------+--------------------------------------------+---------------------
//  input    | in_action, in_operand_a, in_operand_b      | start & !busy
//  result   | out_field_result, out_divide_by_zero       | out_strobe, 1 cycle
//  config   | cfg_index, cfg_wdata                       | cfg_we, no wait
//
//  Sequence: a field multiplication runs on the shared multiplier (up to 4
//  reduction steps per cycle). Add and divide by zero answer in the cycle
//  after start. Multiply runs one pass of the multiplier. Power runs
//  square-and-multiply: per exponent bit a sequencer step plus a square
//  (none after the top bit), one more sequencer step plus a multiply for
//  each set bit, and a closing sequencer step; divide is a power by
//  2^m-2 whose closing step starts one final multiply.
//  Reset: synchronous, active low; restores degree 8 and polynomial 0x11B.
//  Stalls: busy is high while a transaction is in progress; the receiver
//  cannot stall, so every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit #(
  parameter int MAX_DEGREE = bfau_pkg::DEFAULT_MAX_DEGREE
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // input transaction
  input  wire                             start,
  output logic                            busy,
  input  wire  [1:0]                      in_action,
  input  wire  [bfau_pkg::FIELD_W-1:0]    in_operand_a,
  input  wire  [bfau_pkg::FIELD_W-1:0]    in_operand_b,
  // result transaction
  output logic                            out_strobe,
  output logic [bfau_pkg::FIELD_W-1:0]    out_field_result,
  output logic                            out_divide_by_zero,
  // configuration writes
  input  wire                             cfg_we,
  input  wire  [bfau_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [bfau_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Element and counter widths follow the largest degree
  localparam int EW    = MAX_DEGREE;
  localparam int MW    = $clog2(MAX_DEGREE + 1);
  localparam int IW    = $clog2(MAX_DEGREE);
  localparam int CW    = $clog2(MAX_DEGREE + bfau_pkg::DIGIT_BITS + 1);
  localparam int EXP_W = (MAX_DEGREE > bfau_pkg::FIELD_W) ? MAX_DEGREE : bfau_pkg::FIELD_W;
  localparam logic [5:0] MAX_DEG6 = 6'(MAX_DEGREE);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  bfau_pkg::state_t              state_r, state_nxt;
  bfau_pkg::phase_t              phase_r, phase_nxt;
  bfau_pkg::act_t                op_r, op_nxt;
  logic [bfau_pkg::DEGREE_W-1:0] fdeg_r, fdeg_nxt;
  logic [bfau_pkg::POLY_W-1:0]   poly_r, poly_nxt;
  logic [EW-1:0]                 acc_r, acc_nxt;
  logic [EW-1:0]                 base_r, base_nxt;
  logic [EW-1:0]                 opa_r, opa_nxt;
  logic [EXP_W-1:0]              exp_r, exp_nxt;
  logic [EW-1:0]                 mx_r, mx_nxt;
  logic [EW-1:0]                 my_r, my_nxt;
  logic [EW-1:0]                 pr_r, pr_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  logic [bfau_pkg::FIELD_W-1:0]  res_r, res_nxt;
  logic                          dz_r, dz_nxt;

  // --------------------------------------------------------------------------
  // Field description derived from the configuration
  // --------------------------------------------------------------------------
  logic [MW-1:0] eff_m;
  logic [IW-1:0] top_idx;
  logic [EW-1:0] mask;
  logic [EW-1:0] low_poly;
  logic [MW-1:0] align_sh;
  logic [EW-1:0] op_a;
  logic [EW-1:0] op_b;

  always_comb begin
    // clamp the degree into 1..MAX_DEGREE
    if ({1'b0, fdeg_r} > MAX_DEG6) begin
      eff_m = MW'(MAX_DEGREE);
    end else if (fdeg_r == '0) begin
      eff_m = MW'(1);
    end else begin
      eff_m = MW'(fdeg_r);
    end
  end

  assign top_idx  = IW'(eff_m - MW'(1));
  assign mask     = ~({EW{1'b1}} << eff_m);
  assign low_poly = EW'(poly_r) & mask;
  assign align_sh = MW'(MAX_DEGREE) - eff_m;
  assign op_a     = EW'(in_operand_a) & mask;
  assign op_b     = EW'(in_operand_b) & mask;

  // --------------------------------------------------------------------------
  // Shared multiplier: up to DIGIT_BITS shift-and-reduce steps per cycle, taking
  // multiplier bits from the top of the left-aligned operand
  // --------------------------------------------------------------------------
  logic [EW-1:0] mul_prod;
  logic [EW-1:0] my_shift;
  logic          mul_last;

  always_comb begin
    logic [EW-1:0] prod;
    logic [EW-1:0] yb;
    logic          fb;
    prod = pr_r;
    yb   = my_r;
    fb   = 1'b0;
    for (int j = 0; j < bfau_pkg::DIGIT_BITS; j++) begin
      if (CW'(j) < cnt_r) begin
        fb   = prod[top_idx];
        prod = ((prod << 1) & mask) ^ (fb ? low_poly : '0);
        if (yb[EW-1]) begin
          prod = prod ^ mx_r;
        end
        yb = yb << 1;
      end
    end
    mul_prod = prod;
    my_shift = yb;
  end

  assign mul_last = (cnt_r <= CW'(bfau_pkg::DIGIT_BITS));

  // --------------------------------------------------------------------------
  // Sequencer and datapath next state
  // --------------------------------------------------------------------------
  logic          mul_go;
  logic [EW-1:0] mul_x;
  logic [EW-1:0] mul_y;
  logic          fin_go;
  logic [EW-1:0] fin_val;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    op_nxt         = op_r;
    fdeg_nxt       = fdeg_r;
    poly_nxt       = poly_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    opa_nxt        = opa_r;
    exp_nxt        = exp_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    pr_nxt         = pr_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    res_nxt        = res_r;
    dz_nxt         = dz_r;
    mul_go         = 1'b0;
    mul_x          = '0;
    mul_y          = '0;
    fin_go         = 1'b0;
    fin_val        = '0;

    // configuration writes are to arrive only while idle; the user must ensure it, the block has no check for it
    if (cfg_we) begin
      case (bfau_pkg::cfg_idx_t'(cfg_index))
        bfau_pkg::CFG_DEGREE: fdeg_nxt = cfg_wdata[bfau_pkg::DEGREE_W-1:0];
        bfau_pkg::CFG_POLY:   poly_nxt = cfg_wdata[bfau_pkg::POLY_W-1:0];
        default:              fdeg_nxt = fdeg_r;
      endcase
    end

    case (state_r)
      bfau_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt = bfau_pkg::act_t'(in_action);
          case (bfau_pkg::act_t'(in_action))
            bfau_pkg::ACT_ADD: begin
              fin_go  = 1'b1;
              fin_val = op_a ^ op_b;
            end
            bfau_pkg::ACT_MUL: begin
              phase_nxt = bfau_pkg::PH_FIN;
              mul_go    = 1'b1;
              mul_x     = op_a;
              mul_y     = op_b;
            end
            bfau_pkg::ACT_DIV: begin
              if (op_b == '0) begin
                res_nxt        = '0;
                dz_nxt         = 1'b1;
                out_strobe_nxt = 1'b1;
              end else begin
                // inverse as b^(2^m-2): the mask with its low bit dropped
                opa_nxt   = op_a;
                acc_nxt   = EW'(1);
                base_nxt  = op_b;
                exp_nxt   = EXP_W'(mask) & ~EXP_W'(1);
                state_nxt = bfau_pkg::ST_STEP;
              end
            end
            bfau_pkg::ACT_POW: begin
              acc_nxt   = EW'(1);
              base_nxt  = op_a;
              exp_nxt   = EXP_W'(in_operand_b);
              state_nxt = bfau_pkg::ST_STEP;
            end
            default: state_nxt = bfau_pkg::ST_IDLE;
          endcase
        end
      end

      bfau_pkg::ST_STEP: begin
        if (exp_r == '0) begin
          if (op_r == bfau_pkg::ACT_DIV) begin
            phase_nxt = bfau_pkg::PH_FIN;
            mul_go    = 1'b1;
            mul_x     = opa_r;
            mul_y     = acc_r;
          end else begin
            fin_go  = 1'b1;
            fin_val = acc_r;
          end
        end else if (exp_r[0]) begin
          // fold the base in, then come back to square
          phase_nxt = bfau_pkg::PH_ACC;
          mul_go    = 1'b1;
          mul_x     = acc_r;
          mul_y     = base_r;
          exp_nxt   = {exp_r[EXP_W-1:1], 1'b0};
        end else begin
          exp_nxt = exp_r >> 1;
          // skip the square when no exponent bit is left to use it
          if (exp_r[EXP_W-1:1] != '0) begin
            phase_nxt = bfau_pkg::PH_SQR;
            mul_go    = 1'b1;
            mul_x     = base_r;
            mul_y     = base_r;
          end
        end
      end

      bfau_pkg::ST_MUL: begin
        pr_nxt  = mul_prod;
        my_nxt  = my_shift;
        cnt_nxt = mul_last ? '0 : cnt_r - CW'(bfau_pkg::DIGIT_BITS);
        if (mul_last) begin
          case (phase_r)
            bfau_pkg::PH_ACC: begin
              acc_nxt   = mul_prod;
              state_nxt = bfau_pkg::ST_STEP;
            end
            bfau_pkg::PH_SQR: begin
              base_nxt  = mul_prod;
              state_nxt = bfau_pkg::ST_STEP;
            end
            bfau_pkg::PH_FIN: begin
              fin_go  = 1'b1;
              fin_val = mul_prod;
            end
            default: state_nxt = bfau_pkg::ST_IDLE;
          endcase
        end
      end

      default: state_nxt = bfau_pkg::ST_IDLE;
    endcase

    // load the shared multiplier
    if (mul_go) begin
      mx_nxt    = mul_x;
      my_nxt    = mul_y << align_sh;
      pr_nxt    = '0;
      cnt_nxt   = CW'(eff_m);
      state_nxt = bfau_pkg::ST_MUL;
    end

    // present the result for one cycle and drop back to idle
    if (fin_go) begin
      res_nxt        = bfau_pkg::FIELD_W'(fin_val & mask);
      dz_nxt         = 1'b0;
      out_strobe_nxt = 1'b1;
      state_nxt      = bfau_pkg::ST_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // State register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfau_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
      fdeg_r       <= bfau_pkg::DEGREE_RESET;
      poly_r       <= bfau_pkg::POLY_RESET;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      fdeg_r       <= fdeg_nxt;
      poly_r       <= poly_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    op_r    <= op_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    opa_r   <= opa_nxt;
    exp_r   <= exp_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    pr_r    <= pr_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    dz_r    <= dz_nxt;
  end

  assign busy               = (state_r != bfau_pkg::ST_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_field_result   = res_r;
  assign out_divide_by_zero = dz_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_divide_by_zero |-> out_field_result == '0)
    else $error("divide by zero result is not zero");

  a_add_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == bfau_pkg::ACT_ADD |=> out_strobe && !busy)
    else $error("add did not complete in one cycle");

  a_mul_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == bfau_pkg::ACT_MUL |=> busy && !out_strobe)
    else $error("multiply did not enter the sequencer");

  a_mul_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfau_pkg::ST_MUL |-> cnt_r != '0)
    else $error("multiplier running with an empty step count");

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(busy) |-> !busy)
    else $error("result shown while a transaction is still running");

endmodule : binary_field_arithmetic_unit
`default_nettype wire
